### sv/asgr_pkg.sv
`default_nettype none

package asgr_pkg;

    localparam int MAX_PARAMS_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_BEL  = 8'h07;
    localparam logic [7:0] BYTE_CSI  = 8'h5B;  // '['
    localparam logic [7:0] BYTE_OSC  = 8'h5D;  // ']'
    localparam logic [7:0] BYTE_SGR  = 8'h6D;  // 'm'
    localparam logic [7:0] BYTE_SEP  = 8'h3B;  // ';'
    localparam logic [7:0] BYTE_D0   = 8'h30;  // '0'
    localparam logic [7:0] BYTE_D9   = 8'h39;  // '9'

    localparam logic [3:0]  COLOR_DEFAULT = 4'd8;
    localparam logic [19:0] VALUE_MAX     = 20'd65535;

    localparam logic [15:0] SGR_RESET      = 16'd0;
    localparam logic [15:0] SGR_BOLD       = 16'd1;
    localparam logic [15:0] SGR_UNDERLINE  = 16'd4;
    localparam logic [15:0] SGR_INVERSE    = 16'd7;
    localparam logic [15:0] SGR_BOLD_OFF   = 16'd22;
    localparam logic [15:0] SGR_UL_OFF     = 16'd24;
    localparam logic [15:0] SGR_INV_OFF    = 16'd27;
    localparam logic [15:0] SGR_FG_BASE    = 16'd30;
    localparam logic [15:0] SGR_FG_LAST    = 16'd37;
    localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
    localparam logic [15:0] SGR_BG_BASE    = 16'd40;
    localparam logic [15:0] SGR_BG_LAST    = 16'd47;
    localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;

    typedef enum logic [1:0] {
        OP_EMIT,
        OP_RESET,
        OP_APPLY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        FS_NORMAL,
        FS_ESCAPE,
        FS_CSI,
        FS_OSC,
        FS_READ,
        FS_PUSH
    } t_fstate;

endpackage

`default_nettype wire

### sv/asgr_fifo.sv
`default_nettype none

module asgr_fifo #(
    parameter int DEPTH = asgr_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire asgr_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output asgr_pkg::t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    asgr_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/asgr_front.sv
`default_nettype none

module asgr_front #(
    parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_stall,
    output logic            o_push,
    output asgr_pkg::t_cmd  o_cmd,
    input  wire logic       i_full
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W = $clog2(MAX_PARAMS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PARAMS);
    localparam logic [CNT_W-1:0] CNT_OVF  = CNT_W'(MAX_PARAMS + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARAMS - 1);

    asgr_pkg::t_fstate r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]       r_acc, n_acc;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_last, n_last;

    logic [15:0]       r_store [MAX_PARAMS];
    logic [15:0]       r_rd_data;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [15:0]       wr_data;

    logic              parsing;
    logic              accept;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W-1:0]  cur_idx;
    logic [7:0]        digit_full;
    logic [19:0]       prod;
    logic [15:0]       acc_next;
    logic              is_digit;

    assign cnt_m1     = r_cnt - CNT_W'(1);
    assign cur_idx    = cnt_m1[IDX_W-1:0];
    assign digit_full = i_byte - asgr_pkg::BYTE_D0;
    assign prod       = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + {16'b0, digit_full[3:0]};
    assign acc_next   = (prod > asgr_pkg::VALUE_MAX) ? 16'hFFFF : prod[15:0];
    assign is_digit   = (i_byte inside {[asgr_pkg::BYTE_D0:asgr_pkg::BYTE_D9]});

    assign parsing = (r_state == asgr_pkg::FS_NORMAL) || (r_state == asgr_pkg::FS_ESCAPE)
                  || (r_state == asgr_pkg::FS_CSI) || (r_state == asgr_pkg::FS_OSC);
    assign o_stall = !parsing || i_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_last  = r_last;
        o_push  = 1'b0;
        o_cmd   = '{op: asgr_pkg::OP_EMIT, data: {8'h00, i_byte}};
        wr_en   = 1'b0;
        wr_addr = cur_idx;
        wr_data = r_acc;
        case (r_state)
            asgr_pkg::FS_NORMAL: begin
                if (accept) begin
                    if (i_byte == asgr_pkg::BYTE_ESC) begin
                        n_state = asgr_pkg::FS_ESCAPE;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
            asgr_pkg::FS_ESCAPE: begin
                if (accept) begin
                    if (i_byte == asgr_pkg::BYTE_CSI) begin
                        n_state = asgr_pkg::FS_CSI;
                        n_cnt   = '0;
                    end else if (i_byte == asgr_pkg::BYTE_OSC) begin
                        n_state = asgr_pkg::FS_OSC;
                    end else begin
                        if (i_byte == asgr_pkg::BYTE_SGR) begin
                            o_push = 1'b1;
                            o_cmd  = '{op: asgr_pkg::OP_RESET, data: 16'h0000};
                        end
                        n_state = asgr_pkg::FS_NORMAL;
                    end
                end
            end
            asgr_pkg::FS_CSI: begin
                if (accept) begin
                    if (is_digit) begin
                        if (r_cnt == '0) begin
                            n_cnt = CNT_W'(1);
                            n_acc = {12'h000, digit_full[3:0]};
                        end else if (r_cnt != CNT_OVF) begin
                            n_acc = acc_next;
                        end
                    end else if (i_byte == asgr_pkg::BYTE_SEP) begin
                        // The current parameter lives in r_acc; a separator
                        // closes it into the store and opens the next one.
                        if (r_cnt == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            wr_data = 16'h0000;
                            n_acc   = 16'h0000;
                            n_cnt   = (MAX_PARAMS > 1) ? CNT_W'(2) : CNT_OVF;
                        end else if (r_cnt != CNT_OVF) begin
                            wr_en = 1'b1;
                            n_acc = 16'h0000;
                            n_cnt = (r_cnt == CNT_MAX) ? CNT_OVF : r_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_state = asgr_pkg::FS_NORMAL;
                        if (i_byte == asgr_pkg::BYTE_SGR) begin
                            if (r_cnt == '0) begin
                                o_push = 1'b1;
                                o_cmd  = '{op: asgr_pkg::OP_RESET, data: 16'h0000};
                            end else begin
                                wr_en   = (r_cnt != CNT_OVF);
                                n_idx   = '0;
                                n_last  = (r_cnt == CNT_OVF) ? IDX_LAST : cur_idx;
                                n_state = asgr_pkg::FS_READ;
                            end
                        end
                    end
                end
            end
            asgr_pkg::FS_OSC: begin
                if (accept && (i_byte == asgr_pkg::BYTE_BEL
                               || i_byte == asgr_pkg::BYTE_ESC)) begin
                    n_state = asgr_pkg::FS_NORMAL;
                end
            end
            asgr_pkg::FS_READ: begin
                n_state = asgr_pkg::FS_PUSH;
            end
            asgr_pkg::FS_PUSH: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    o_cmd  = '{op: asgr_pkg::OP_APPLY, data: r_rd_data};
                    if (r_idx == r_last) begin
                        n_state = asgr_pkg::FS_NORMAL;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = asgr_pkg::FS_READ;
                    end
                end
            end
            default: begin
                n_state = asgr_pkg::FS_NORMAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rd_data <= r_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asgr_pkg::FS_NORMAL;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

`default_nettype wire

### sv/asgr_back.sv
`default_nettype none

module asgr_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire asgr_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_bold,
    output logic            o_underline,
    output logic            o_inverse,
    output logic [3:0]      o_fg_color,
    output logic [3:0]      o_bg_color
);

    logic       r_bold, n_bold;
    logic       r_underline, n_underline;
    logic       r_inverse, n_inverse;
    logic [3:0] r_fg, n_fg;
    logic [3:0] r_bg, n_bg;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_bold;
    logic       r_out_underline;
    logic       r_out_inverse;
    logic [3:0] r_out_fg;
    logic [3:0] r_out_bg;

    logic        slot_free;
    logic        emit;
    logic [15:0] fg_off;
    logic [15:0] bg_off;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_pop     = i_cmd_valid && ((i_cmd.op != asgr_pkg::OP_EMIT) || slot_free);
    assign emit      = o_pop && (i_cmd.op == asgr_pkg::OP_EMIT);
    assign fg_off    = i_cmd.data - asgr_pkg::SGR_FG_BASE;
    assign bg_off    = i_cmd.data - asgr_pkg::SGR_BG_BASE;

    always_comb begin
        n_bold      = r_bold;
        n_underline = r_underline;
        n_inverse   = r_inverse;
        n_fg        = r_fg;
        n_bg        = r_bg;
        if (o_pop) begin
            case (i_cmd.op)
                asgr_pkg::OP_RESET: begin
                    n_bold      = 1'b0;
                    n_underline = 1'b0;
                    n_inverse   = 1'b0;
                    n_fg        = asgr_pkg::COLOR_DEFAULT;
                    n_bg        = asgr_pkg::COLOR_DEFAULT;
                end
                asgr_pkg::OP_APPLY: begin
                    if (i_cmd.data == asgr_pkg::SGR_RESET) begin
                        n_bold      = 1'b0;
                        n_underline = 1'b0;
                        n_inverse   = 1'b0;
                        n_fg        = asgr_pkg::COLOR_DEFAULT;
                        n_bg        = asgr_pkg::COLOR_DEFAULT;
                    end else if (i_cmd.data == asgr_pkg::SGR_BOLD) begin
                        n_bold = 1'b1;
                    end else if (i_cmd.data == asgr_pkg::SGR_UNDERLINE) begin
                        n_underline = 1'b1;
                    end else if (i_cmd.data == asgr_pkg::SGR_INVERSE) begin
                        n_inverse = 1'b1;
                    end else if (i_cmd.data == asgr_pkg::SGR_BOLD_OFF) begin
                        n_bold = 1'b0;
                    end else if (i_cmd.data == asgr_pkg::SGR_UL_OFF) begin
                        n_underline = 1'b0;
                    end else if (i_cmd.data == asgr_pkg::SGR_INV_OFF) begin
                        n_inverse = 1'b0;
                    end else if (i_cmd.data inside {[asgr_pkg::SGR_FG_BASE:
                                                     asgr_pkg::SGR_FG_LAST]}) begin
                        n_fg = fg_off[3:0];
                    end else if (i_cmd.data == asgr_pkg::SGR_FG_DEFAULT) begin
                        n_fg = asgr_pkg::COLOR_DEFAULT;
                    end else if (i_cmd.data inside {[asgr_pkg::SGR_BG_BASE:
                                                     asgr_pkg::SGR_BG_LAST]}) begin
                        n_bg = bg_off[3:0];
                    end else if (i_cmd.data == asgr_pkg::SGR_BG_DEFAULT) begin
                        n_bg = asgr_pkg::COLOR_DEFAULT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bold      <= 1'b0;
            r_underline <= 1'b0;
            r_inverse   <= 1'b0;
            r_fg        <= asgr_pkg::COLOR_DEFAULT;
            r_bg        <= asgr_pkg::COLOR_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            r_bold      <= n_bold;
            r_underline <= n_underline;
            r_inverse   <= n_inverse;
            r_fg        <= n_fg;
            r_bg        <= n_bg;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // The word captures the attributes in force before this command; a
    // character command never changes them.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char      <= i_cmd.data[7:0];
            r_out_bold      <= r_bold;
            r_out_underline <= r_underline;
            r_out_inverse   <= r_inverse;
            r_out_fg        <= r_fg;
            r_out_bg        <= r_bg;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_bold      = r_out_bold;
    assign o_underline = r_out_underline;
    assign o_inverse   = r_out_inverse;
    assign o_fg_color  = r_out_fg;
    assign o_bg_color  = r_out_bg;

endmodule

`default_nettype wire

### sv/ansi_sgr_escape_parser.sv
// Terminal byte stream parser that strips escape sequences and tags each
// displayed byte with the current SGR attributes.
// Input channel: i_valid / o_stall with i_in_byte. A word is taken on a
// rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_out_char, o_bold, o_underline,
// o_inverse, o_fg_color and o_bg_color. Only displayable bytes produce a
// word; escape, CSI and OSC bytes are consumed silently.
// A displayed byte passes through the command queue and then the output
// register before it appears on the output.
// Throughput: one byte per cycle in plain text and while collecting CSI
// parameters, while the command queue has room. A CSI sequence ending in
// 'm' holds o_stall high while the front end reads its stored parameters
// (up to MAX_PARAMS) from the parameter store into the queue one by one.
// When i_stall holds the output word, the queue fills and then o_stall
// rises; nothing is dropped.
// Reset (synchronous, i_rst_n low) returns to normal text mode, clears
// bold, underline and inverse, sets both colors to default (8) and
// empties the queue. The parameter store needs no clearing.
`default_nettype none

module ansi_sgr_escape_parser #(
    parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_char,
    output logic            o_bold,
    output logic            o_underline,
    output logic            o_inverse,
    output logic [3:0]      o_fg_color,
    output logic [3:0]      o_bg_color
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    asgr_pkg::t_cmd q_in_cmd;
    asgr_pkg::t_cmd q_out_cmd;

    asgr_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_byte  (i_in_byte),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_cmd   (q_in_cmd),
        .i_full  (q_full)
    );

    asgr_fifo #(
        .DEPTH(asgr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    asgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_bold      (o_bold),
        .o_underline (o_underline),
        .o_inverse   (o_inverse),
        .o_fg_color  (o_fg_color),
        .o_bg_color  (o_bg_color)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("command pushed into a full queue");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fg_color <= asgr_pkg::COLOR_DEFAULT)
                 && (o_bg_color <= asgr_pkg::COLOR_DEFAULT))
        else $error("color index beyond default");

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
    import asgr_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       bold;
        logic       underline;
        logic       inverse;
        logic [3:0] fg;
        logic [3:0] bg;
    } t_glyph;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        t_glyph     glyph;
    } t_stim_row;

    localparam t_glyph NO_GLYPH       = '0;
    localparam int     DIRECTED_ROWS  = 40;
    localparam int     PHASE_BYTES    = 130;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 16;

    localparam logic [15:0] NAMED_CODES [9] = '{
        SGR_RESET, SGR_BOLD, SGR_UNDERLINE, SGR_INVERSE, SGR_BOLD_OFF,
        SGR_UL_OFF, SGR_INV_OFF, SGR_FG_DEFAULT, SGR_BG_DEFAULT
    };

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, COLOR_DEFAULT, COLOR_DEFAULT}},
        '{8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, COLOR_DEFAULT, COLOR_DEFAULT}},
        // A leading empty parameter counts as zero, then bold and background 4.
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_CSI, 1'b0, NO_GLYPH},
        '{BYTE_SEP, 1'b0, NO_GLYPH},
        '{"1", 1'b0, NO_GLYPH},
        '{BYTE_SEP, 1'b0, NO_GLYPH},
        '{"4", 1'b0, NO_GLYPH},
        '{"4", 1'b0, NO_GLYPH},
        '{BYTE_SGR, 1'b0, NO_GLYPH},
        '{"A", 1'b0, NO_GLYPH},
        // The short escape form clears everything.
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_SGR, 1'b0, NO_GLYPH},
        '{"B", 1'b1, '{"B", 1'b0, 1'b0, 1'b0, COLOR_DEFAULT, COLOR_DEFAULT}},
        // A value past the top saturates and is then an unknown code.
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_CSI, 1'b0, NO_GLYPH},
        '{"7", 1'b0, NO_GLYPH},
        '{"0", 1'b0, NO_GLYPH},
        '{"0", 1'b0, NO_GLYPH},
        '{"0", 1'b0, NO_GLYPH},
        '{"0", 1'b0, NO_GLYPH},
        '{BYTE_SEP, 1'b0, NO_GLYPH},
        '{"7", 1'b0, NO_GLYPH},
        '{BYTE_SGR, 1'b0, NO_GLYPH},
        '{"a", 1'b0, NO_GLYPH},
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_OSC, 1'b0, NO_GLYPH},
        '{"x", 1'b0, NO_GLYPH},
        '{BYTE_BEL, 1'b0, NO_GLYPH},
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{"q", 1'b0, NO_GLYPH},
        // A CSI sequence that ends in something other than m does nothing.
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_CSI, 1'b0, NO_GLYPH},
        '{"3", 1'b0, NO_GLYPH},
        '{"x", 1'b0, NO_GLYPH},
        '{"b", 1'b0, NO_GLYPH},
        '{BYTE_ESC, 1'b0, NO_GLYPH},
        '{BYTE_CSI, 1'b0, NO_GLYPH},
        '{BYTE_SGR, 1'b0, NO_GLYPH},
        '{"C", 1'b1, '{"C", 1'b0, 1'b0, 1'b0, COLOR_DEFAULT, COLOR_DEFAULT}}
    };

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_bold;
    logic       o_underline;
    logic       o_inverse;
    logic [3:0] o_fg_color;
    logic [3:0] o_bg_color;

    // Parser shadow state.
    t_fstate     parse_mode;
    logic [15:0] param_value [MAX_PARAMS_DEF];
    int          param_count;
    logic        bold_on;
    logic        underline_on;
    logic        inverse_on;
    logic [3:0]  fg_now;
    logic [3:0]  bg_now;

    t_glyph     glyph_queue [$];
    logic [7:0] byte_plan [$];

    int error_count    = 0;
    int bytes_sent     = 0;
    int glyphs_checked = 0;
    int sgr_applied    = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    ansi_sgr_escape_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_bold      (o_bold),
        .o_underline (o_underline),
        .o_inverse   (o_inverse),
        .o_fg_color  (o_fg_color),
        .o_bg_color  (o_bg_color)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function void clear_attributes();
        bold_on      = 1'b0;
        underline_on = 1'b0;
        inverse_on   = 1'b0;
        fg_now       = COLOR_DEFAULT;
        bg_now       = COLOR_DEFAULT;
    endfunction

    function void open_param();
        if (param_count < MAX_PARAMS_DEF) begin
            param_value[param_count] = '0;
            param_count++;
        end else begin
            param_count = MAX_PARAMS_DEF + 1;
        end
    endfunction

    function automatic void push_digit(logic [3:0] d);
        logic [19:0] v;
        if (param_count == 0)
            open_param();
        if (param_count > MAX_PARAMS_DEF)
            return;
        v = {4'b0, param_value[param_count - 1]} * 20'd10 + {16'b0, d};
        if (v > VALUE_MAX)
            v = VALUE_MAX;
        param_value[param_count - 1] = v[15:0];
    endfunction

    function void apply_code(logic [15:0] code);
        if (code == SGR_RESET) begin
            clear_attributes();
        end else if (code == SGR_BOLD) begin
            bold_on = 1'b1;
        end else if (code == SGR_UNDERLINE) begin
            underline_on = 1'b1;
        end else if (code == SGR_INVERSE) begin
            inverse_on = 1'b1;
        end else if (code == SGR_BOLD_OFF) begin
            bold_on = 1'b0;
        end else if (code == SGR_UL_OFF) begin
            underline_on = 1'b0;
        end else if (code == SGR_INV_OFF) begin
            inverse_on = 1'b0;
        end else if (code >= SGR_FG_BASE && code <= SGR_FG_LAST) begin
            fg_now = 4'(code - SGR_FG_BASE);
        end else if (code == SGR_FG_DEFAULT) begin
            fg_now = COLOR_DEFAULT;
        end else if (code >= SGR_BG_BASE && code <= SGR_BG_LAST) begin
            bg_now = 4'(code - SGR_BG_BASE);
        end else if (code == SGR_BG_DEFAULT) begin
            bg_now = COLOR_DEFAULT;
        end
    endfunction

    function automatic void apply_sgr_list();
        int n;
        n = (param_count > MAX_PARAMS_DEF) ? MAX_PARAMS_DEF : param_count;
        sgr_applied++;
        if (n == 0)
            apply_code(SGR_RESET);
        for (int k = 0; k < n; k++)
            apply_code(param_value[k]);
    endfunction

    function void reset_parser();
        parse_mode  = FS_NORMAL;
        param_count = 0;
        foreach (param_value[k])
            param_value[k] = '0;
        clear_attributes();
    endfunction

    // Advances the shadow parser by one byte; returns 1 when the byte is displayed.
    function automatic bit parse_byte(input logic [7:0] b, output t_glyph g);
        g = NO_GLYPH;
        case (parse_mode)
            FS_NORMAL: begin
                if (b == BYTE_ESC) begin
                    parse_mode = FS_ESCAPE;
                end else begin
                    g = '{b, bold_on, underline_on, inverse_on, fg_now, bg_now};
                    return 1'b1;
                end
            end
            FS_ESCAPE: begin
                if (b == BYTE_CSI) begin
                    parse_mode  = FS_CSI;
                    param_count = 0;
                end else if (b == BYTE_OSC) begin
                    parse_mode = FS_OSC;
                end else begin
                    if (b == BYTE_SGR)
                        clear_attributes();
                    parse_mode = FS_NORMAL;
                end
            end
            FS_CSI: begin
                if (b >= BYTE_D0 && b <= BYTE_D9) begin
                    push_digit(4'(b - BYTE_D0));
                end else if (b == BYTE_SEP) begin
                    if (param_count == 0)
                        open_param();
                    open_param();
                end else begin
                    if (b == BYTE_SGR)
                        apply_sgr_list();
                    parse_mode = FS_NORMAL;
                end
            end
            default: begin
                if (b == BYTE_BEL || b == BYTE_ESC)
                    parse_mode = FS_NORMAL;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch on %s at word %0d: got %0h, expected %0h",
                 what, glyphs_checked, got, want);
        error_count++;
    endtask

    task automatic check_glyph(t_glyph got);
        t_glyph want;
        if (glyph_queue.size() == 0) begin
            report_mismatch("unexpected word", got.ch, 8'h00);
            return;
        end
        want = glyph_queue.pop_front();
        if (got.ch !== want.ch)
            report_mismatch("out_char", got.ch, want.ch);
        if (got.bold !== want.bold)
            report_mismatch("bold", 8'(got.bold), 8'(want.bold));
        if (got.underline !== want.underline)
            report_mismatch("underline", 8'(got.underline), 8'(want.underline));
        if (got.inverse !== want.inverse)
            report_mismatch("inverse", 8'(got.inverse), 8'(want.inverse));
        if (got.fg !== want.fg)
            report_mismatch("fg_color", 8'(got.fg), 8'(want.fg));
        if (got.bg !== want.bg)
            report_mismatch("bg_color", 8'(got.bg), 8'(want.bg));
    endtask

    // Offers one word, waits for it to be taken and records what it should display.
    task automatic send_word(input logic [7:0] b, input logic typed, input t_glyph typed_glyph);
        t_glyph g;
        bit     shown;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        shown = parse_byte(b, g);
        if (typed)
            glyph_queue.push_back(typed_glyph);
        else if (shown)
            glyph_queue.push_back(g);
        bytes_sent++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == BYTE_ESC);
        return b;
    endfunction

    function automatic void plan_number();
        int    sel;
        int    value;
        string digits;
        sel = $urandom_range(11);
        if (sel < 5)
            value = NAMED_CODES[$urandom_range(8)];
        else if (sel < 7)
            value = SGR_FG_BASE + $urandom_range(7);
        else if (sel < 9)
            value = SGR_BG_BASE + $urandom_range(7);
        else if (sel == 9)
            value = $urandom_range(99);
        else if (sel == 10)
            value = $urandom_range(99999, 65530);
        else
            return;  // empty parameter
        if ($urandom_range(9) == 0)
            byte_plan.push_back(BYTE_D0);
        digits = $sformatf("%0d", value);
        for (int k = 0; k < digits.len(); k++)
            byte_plan.push_back(digits[k]);
    endfunction

    // Well-formed SGR sequences with random content (the most common kind),
    // plus text runs, other escapes, OSC strings, broken sequences and raw noise.
    function automatic void plan_sequence();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 40) begin
            byte_plan.push_back(BYTE_ESC);
            byte_plan.push_back(BYTE_CSI);
            n = $urandom_range(11);
            for (int k = 0; k < n; k++) begin
                if (k > 0)
                    byte_plan.push_back(BYTE_SEP);
                plan_number();
            end
            byte_plan.push_back(BYTE_SGR);
        end else if (kind < 55) begin
            n = $urandom_range(4, 1);
            repeat (n) byte_plan.push_back(text_byte());
        end else if (kind < 65) begin
            byte_plan.push_back(BYTE_ESC);
            byte_plan.push_back(BYTE_SGR);
        end else if (kind < 75) begin
            byte_plan.push_back(BYTE_ESC);
            byte_plan.push_back(BYTE_OSC);
            n = $urandom_range(5);
            repeat (n) begin
                do
                    b = 8'($urandom_range(255));
                while (b == BYTE_BEL || b == BYTE_ESC);
                byte_plan.push_back(b);
            end
            byte_plan.push_back($urandom_range(1) ? BYTE_BEL : BYTE_ESC);
        end else if (kind < 83) begin
            byte_plan.push_back(BYTE_ESC);
            do
                b = 8'($urandom_range(255));
            while (b == BYTE_CSI || b == BYTE_OSC || b == BYTE_SGR);
            byte_plan.push_back(b);
        end else if (kind < 90) begin
            byte_plan.push_back(BYTE_ESC);
            byte_plan.push_back(BYTE_CSI);
            n = $urandom_range(4);
            repeat (n) begin
                if ($urandom_range(3) == 0)
                    byte_plan.push_back(BYTE_SEP);
                else
                    byte_plan.push_back(8'(BYTE_D0 + $urandom_range(9)));
            end
            do
                b = 8'($urandom_range(255));
            while ((b >= BYTE_D0 && b <= BYTE_D9) || b == BYTE_SEP || b == BYTE_SGR);
            byte_plan.push_back(b);
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) byte_plan.push_back(8'($urandom_range(255)));
        end
        // Follow with some text so the new attributes show up on the output.
        if ($urandom_range(9) < 7) begin
            n = $urandom_range(3, 1);
            repeat (n) byte_plan.push_back(text_byte());
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_glyph('{o_out_char, o_bold, o_underline, o_inverse,
                              o_fg_color, o_bg_color});
                glyphs_checked++;
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                     quiet_cycles, glyph_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_start;
        reset_parser();
        send_idle_pct = 23;
        recv_idle_pct = 46;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_word(DIRECTED[r].b, DIRECTED[r].typed, DIRECTED[r].glyph);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 23 : 0;
            phase_start   = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                plan_sequence();
                while (byte_plan.size() != 0)
                    send_word(byte_plan.pop_front(), 1'b0, NO_GLYPH);
            end
        end
        i_valid <= 1'b0;

        while (glyph_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (directed, then random sequences under three stall mixes);",
                 bytes_sent);
        $display("checked %0d displayed words, %0d SGR sequences applied, %0d mismatches.",
                 glyphs_checked, sgr_applied, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
